[hw/rtl/pair_list_sort_index_builder_top_defines.svh]
// Assertion macros shared by the checker.
`ifndef PAIR_LIST_SORT_INDEX_BUILDER_TOP_DEFINES_SVH
`define PAIR_LIST_SORT_INDEX_BUILDER_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define PLSI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define PLSI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hw/rtl/plsi_pkg.sv]
package plsi_pkg;
    localparam int DefMaxParticles = 1024;
    localparam int DefMaxPairs     = 2048;
    localparam int DefDistBits     = 32;
    localparam int CmdW            = 3;
    localparam int PartW           = 10;
    localparam int PosW            = 11;
    localparam int W12             = 12;
    localparam int PcntW           = 11;
    localparam int CfgW            = 32;

    localparam logic [CmdW-1:0] CMD_OFFER = 3'd0;
    localparam logic [CmdW-1:0] CMD_BUILD = 3'd1;
    localparam logic [CmdW-1:0] CMD_RPAIR = 3'd2;
    localparam logic [CmdW-1:0] CMD_RIDX  = 3'd3;
    localparam logic [CmdW-1:0] CMD_BEGIN = 3'd4;

    localparam logic CFG_CUTOFF = 1'b0;
    localparam logic CFG_PCOUNT = 1'b1;

    // One queued command.
    typedef struct packed {
        logic [CmdW-1:0]  cmd;
        logic [63:0]      dsq;
        logic [PartW-1:0] first;
        logic [PartW-1:0] second;
        logic [PosW-1:0]  position;
        logic             in_cut;
    } plsi_op_t;
endpackage

[hw/rtl/plsi_ram.sv]
module plsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hw/rtl/plsi_front.sv]
module plsi_front #(
    parameter int DIST_BITS = plsi_pkg::DefDistBits
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [2:0]             cmd,
    input  logic [DIST_BITS-1:0]   dist_sq,
    input  logic [9:0]             first,
    input  logic [9:0]             second,
    input  logic [10:0]            position,
    input  logic [DIST_BITS-1:0]   cutoff,
    output logic                   q_valid,
    input  logic                   q_ready,
    output plsi_pkg::plsi_op_t     q_op
);
    import plsi_pkg::*;

    // Two-entry queue; the cutoff compare is done on entry.
    plsi_op_t   ent_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic       push, pop;
    plsi_op_t   op_in;

    always_comb
    begin
        op_in          = '0;
        op_in.cmd      = cmd;
        op_in.dsq      = 64'(dist_sq);
        op_in.first    = first;
        op_in.second   = second;
        op_in.position = position;
        op_in.in_cut   = dist_sq < cutoff;
    end

    assign in_ready = cnt_reg != 2'd2;
    assign push     = in_valid && in_ready;
    assign q_valid  = cnt_reg != 2'd0;
    assign pop      = q_valid && q_ready;
    assign q_op     = ent_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        rd_next  = rd_reg ^ pop;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_reg] <= op_in;
        end
    end
endmodule

[hw/rtl/plsi_back.sv]
module plsi_back #(
    parameter int MAX_PARTICLES = plsi_pkg::DefMaxParticles,
    parameter int MAX_PAIRS     = plsi_pkg::DefMaxPairs,
    parameter int DIST_BITS     = plsi_pkg::DefDistBits
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  plsi_pkg::plsi_op_t   q_op,
    input  logic [10:0]          pcount,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [9:0]           pair_first,
    output logic [9:0]           pair_second,
    output logic [DIST_BITS-1:0] pair_dist,
    output logic [11:0]          group_start,
    output logic [11:0]          group_count,
    output logic [11:0]          total_pairs,
    output logic                 accepted,
    output logic                 overflow
);
    import plsi_pkg::*;

    localparam int AW  = $clog2(MAX_PAIRS);
    localparam int CW  = $clog2(MAX_PAIRS + 1);
    localparam int PW  = $clog2(MAX_PARTICLES);
    localparam int PCW = $clog2(MAX_PARTICLES + 1);
    localparam int EW  = 2 * PartW + DIST_BITS;
    localparam int IW  = 2 * W12;
    // An index entry with no group: start -1, count 0.
    localparam logic [IW-1:0] IDX_EMPTY = {{W12{1'b1}}, {W12{1'b0}}};

    typedef enum logic [13:0] {
        S_INIT  = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_OFF2  = 14'b00000000000100,
        S_RDWT  = 14'b00000000001000,
        S_RDGO  = 14'b00000000010000,
        S_CLR   = 14'b00000000100000,
        S_SKEY  = 14'b00000001000000,
        S_SKWT  = 14'b00000010000000,
        S_SPRD  = 14'b00000100000000,
        S_SPWT  = 14'b00001000000000,
        S_SCMP  = 14'b00010000000000,
        S_BRD   = 14'b00100000000000,
        S_BCHK  = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } st_t;

    st_t st_reg, st_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] p_reg, p_next;
    logic [CW-1:0] gst_reg, gst_next;
    logic [PartW-1:0] cur_reg, cur_next;
    logic [PCW-1:0] ci_reg, ci_next;
    logic [EW-1:0] key_reg, key_next;
    plsi_op_t op_reg, op_next;

    logic [9:0] pf_reg, pf_next, ps_reg, ps_next;
    logic [DIST_BITS-1:0] pd_reg, pd_next;
    logic [11:0] gs_reg, gs_next, gc_reg, gc_next;
    logic acc_reg, acc_next, ovf_reg, ovf_next;

    logic          s_we;
    logic [AW-1:0] s_wa, s_ra;
    logic [EW-1:0] s_wd, s_rd;
    logic          i_we;
    logic [PW-1:0] i_wa, i_ra;
    logic [IW-1:0] i_wd, i_rd;

    plsi_ram #(.WIDTH(EW), .DEPTH(MAX_PAIRS)) u_store (
        .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
    );
    plsi_ram #(.WIDTH(IW), .DEPTH(MAX_PARTICLES)) u_index (
        .clk(clk), .we(i_we), .waddr(i_wa), .wdata(i_wd), .raddr(i_ra), .rdata(i_rd)
    );

    logic [PartW-1:0] kf, rf;
    logic [DIST_BITS-1:0] kd, rdd;
    logic key_lt;
    logic [IW-1:0] grp_w;

    assign kf  = key_reg[EW-1 -: PartW];
    assign kd  = key_reg[DIST_BITS-1:0];
    assign rf  = s_rd[EW-1 -: PartW];
    assign rdd = s_rd[DIST_BITS-1:0];
    assign key_lt = (kf != rf) ? (kf < rf) : (kd < rdd);
    assign grp_w = {W12'(gst_reg), W12'(p_reg - gst_reg)};

    assign q_ready   = st_reg == S_IDLE;
    assign out_valid = st_reg == S_OUT;
    assign pair_first  = pf_reg;
    assign pair_second = ps_reg;
    assign pair_dist   = pd_reg;
    assign group_start = gs_reg;
    assign group_count = gc_reg;
    assign total_pairs = W12'(cnt_reg);
    assign accepted    = acc_reg;
    assign overflow    = ovf_reg;

    always_comb
    begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        k_next   = k_reg;
        p_next   = p_reg;
        gst_next = gst_reg;
        cur_next = cur_reg;
        ci_next  = ci_reg;
        key_next = key_reg;
        op_next  = op_reg;
        pf_next  = pf_reg;
        ps_next  = ps_reg;
        pd_next  = pd_reg;
        gs_next  = gs_reg;
        gc_next  = gc_reg;
        acc_next = acc_reg;
        ovf_next = ovf_reg;
        s_we = 1'b0;
        s_wa = AW'(cnt_reg);
        s_wd = '0;
        s_ra = AW'(p_reg);
        i_we = 1'b0;
        i_wa = PW'(cur_reg);
        i_wd = grp_w;
        i_ra = PW'(op_reg.first);
        case (st_reg)
            S_INIT:
            begin
                // Every index entry is emptied once after reset.
                if (32'(ci_reg) < 32'(MAX_PARTICLES))
                begin
                    i_we    = 1'b1;
                    i_wa    = PW'(ci_reg);
                    i_wd    = IDX_EMPTY;
                    ci_next = ci_reg + PCW'(1);
                end
                else
                begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    op_next  = q_op;
                    pf_next  = '0;
                    ps_next  = '0;
                    pd_next  = '0;
                    gs_next  = '1;
                    gc_next  = '0;
                    acc_next = 1'b0;
                    ovf_next = 1'b0;
                    st_next  = S_OUT;
                    case (q_op.cmd)
                        CMD_OFFER:
                        begin
                            if (q_op.in_cut)
                            begin
                                if ((CW+1)'(cnt_reg) + (CW+1)'(2) <= (CW+1)'(MAX_PAIRS))
                                begin
                                    s_we = 1'b1;
                                    s_wd = {q_op.first, q_op.second,
                                            q_op.dsq[DIST_BITS-1:0]};
                                    cnt_next = cnt_reg + CW'(1);
                                    acc_next = 1'b1;
                                    st_next  = S_OFF2;
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                        end
                        CMD_RPAIR:
                        begin
                            if (CW'(q_op.position) < cnt_reg
                                && 32'(q_op.position) < 32'(MAX_PAIRS))
                            begin
                                p_next  = CW'(q_op.position);
                                st_next = S_RDWT;
                            end
                        end
                        CMD_RIDX:
                        begin
                            if (32'(q_op.first) < 32'(MAX_PARTICLES))
                            begin
                                st_next = S_RDWT;
                            end
                        end
                        CMD_BEGIN:
                        begin
                            cnt_next = '0;
                            ci_next  = '0;
                            st_next  = S_CLR;
                        end
                        CMD_BUILD:
                        begin
                            k_next  = CW'(1);
                            st_next = S_SKEY;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_OFF2:
            begin
                s_we = 1'b1;
                s_wd = {op_reg.second, op_reg.first, op_reg.dsq[DIST_BITS-1:0]};
                cnt_next = cnt_reg + CW'(1);
                st_next  = S_OUT;
            end
            S_RDWT:
            begin
                st_next = S_RDGO;
            end
            S_RDGO:
            begin
                if (op_reg.cmd == CMD_RPAIR)
                begin
                    pf_next = s_rd[EW-1 -: PartW];
                    ps_next = s_rd[EW-PartW-1 -: PartW];
                    pd_next = rdd;
                end
                else
                begin
                    gs_next = i_rd[IW-1 -: W12];
                    gc_next = i_rd[W12-1:0];
                end
                st_next = S_OUT;
            end
            S_CLR:
            begin
                // Index entries are cleared one per cycle up to the particle count, capped at MAX_PARTICLES.
                if (32'(ci_reg) < 32'(pcount) && 32'(ci_reg) < 32'(MAX_PARTICLES))
                begin
                    i_we    = 1'b1;
                    i_wa    = PW'(ci_reg);
                    i_wd    = IDX_EMPTY;
                    ci_next = ci_reg + PCW'(1);
                end
                else
                begin
                    st_next = S_OUT;
                end
            end
            // Insertion sort: fetch key at k, then walk down while key < store[p-1].
            S_SKEY:
            begin
                if (k_reg < cnt_reg)
                begin
                    p_next  = k_reg;
                    s_ra    = AW'(k_reg);
                    st_next = S_SKWT;
                end
                else
                begin
                    p_next  = CW'(1);
                    gst_next = '0;
                    s_ra    = '0;
                    st_next = (cnt_reg == '0) ? S_OUT : S_BRD;
                end
            end
            S_SKWT:
            begin
                key_next = s_rd;
                st_next  = S_SPRD;
            end
            S_SPRD:
            begin
                if (p_reg == '0)
                begin
                    s_we = 1'b1;
                    s_wa = '0;
                    s_wd = key_reg;
                    k_next  = k_reg + CW'(1);
                    st_next = S_SKEY;
                end
                else
                begin
                    s_ra    = AW'(p_reg - CW'(1));
                    st_next = S_SPWT;
                end
            end
            S_SPWT:
            begin
                s_ra    = AW'(p_reg - CW'(1));
                st_next = S_SCMP;
            end
            S_SCMP:
            begin
                s_we = 1'b1;
                s_wa = AW'(p_reg);
                if (key_lt)
                begin
                    s_wd   = s_rd;
                    p_next = p_reg - CW'(1);
                    st_next = S_SPRD;
                end
                else
                begin
                    s_wd   = key_reg;
                    k_next = k_reg + CW'(1);
                    st_next = S_SKEY;
                end
            end
            // Index build: slot 0 arrives here, slot 1 is being read.
            S_BRD:
            begin
                cur_next = rf;
                st_next  = S_BCHK;
            end
            // One slot per cycle; the read of the next slot is issued each cycle.
            S_BCHK:
            begin
                if (p_reg >= cnt_reg)
                begin
                    if (32'(cur_reg) < 32'(MAX_PARTICLES))
                    begin
                        i_we = 1'b1;
                    end
                    st_next = S_OUT;
                end
                else if (rf != cur_reg)
                begin
                    if (32'(cur_reg) < 32'(MAX_PARTICLES))
                    begin
                        i_we = 1'b1;
                    end
                    cur_next = rf;
                    gst_next = p_reg;
                    p_next   = p_reg + CW'(1);
                    s_ra     = AW'(p_reg + CW'(1));
                end
                else
                begin
                    p_next = p_reg + CW'(1);
                    s_ra   = AW'(p_reg + CW'(1));
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_INIT;
            cnt_reg <= '0;
            ci_reg  <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            ci_reg  <= ci_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        p_reg   <= p_next;
        gst_reg <= gst_next;
        cur_reg <= cur_next;
        key_reg <= key_next;
        op_reg  <= op_next;
        pf_reg  <= pf_next;
        ps_reg  <= ps_next;
        pd_reg  <= pd_next;
        gs_reg  <= gs_next;
        gc_reg  <= gc_next;
        acc_reg <= acc_next;
        ovf_reg <= ovf_next;
    end
endmodule

[hw/rtl/pair_list_sort_index_builder_top.sv]
// The back end holds one command in flight; the two-entry queue absorbs arrivals.
// The compare-and-shift sort walk over the pair store sets the build time.
// Reset (rst_n, asynchronous, active low) clears control and counts, then an index
// clearing pass over all MAX_PARTICLES entries runs before the first command is taken.
module pair_list_sort_index_builder_top #(
    parameter int MAX_PARTICLES = plsi_pkg::DefMaxParticles,
    parameter int MAX_PAIRS     = plsi_pkg::DefMaxPairs,
    parameter int DIST_BITS     = plsi_pkg::DefDistBits
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           cmd,
    input  logic [DIST_BITS-1:0] dist_sq,
    input  logic [9:0]           first,
    input  logic [9:0]           second,
    input  logic [10:0]          position,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [9:0]           pair_first,
    output logic [9:0]           pair_second,
    output logic [DIST_BITS-1:0] pair_dist,
    output logic [11:0]          group_start,
    output logic [11:0]          group_count,
    output logic [11:0]          total_pairs,
    output logic                 accepted,
    output logic                 overflow
);
    import plsi_pkg::*;

    // Configuration registers.
    logic [DIST_BITS-1:0] cutoff_reg;
    logic [PcntW-1:0]     pcount_reg;
    logic                 q_valid, q_ready;
    plsi_op_t             q_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= '0;
            pcount_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_CUTOFF)
            begin
                cutoff_reg <= DIST_BITS'(64'(cfg_data));
            end
            else
            begin
                pcount_reg <= cfg_data[PcntW-1:0];
            end
        end
    end

    // The front end queues each beat with its cutoff compare done.
    plsi_front #(.DIST_BITS(DIST_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .dist_sq(dist_sq), .first(first), .second(second),
        .position(position), .cutoff(cutoff_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op)
    );

    // The back end owns the store, index and sort sequencer.
    plsi_back #(
        .MAX_PARTICLES(MAX_PARTICLES), .MAX_PAIRS(MAX_PAIRS), .DIST_BITS(DIST_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op),
        .pcount(pcount_reg), .out_valid(out_valid), .out_ready(out_ready),
        .pair_first(pair_first), .pair_second(pair_second), .pair_dist(pair_dist),
        .group_start(group_start), .group_count(group_count),
        .total_pairs(total_pairs), .accepted(accepted), .overflow(overflow)
    );
endmodule

[hw/rtl/plsi_checker.sv]
`include "pair_list_sort_index_builder_top_defines.svh"
module plsi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] total_pairs,
    input logic        accepted,
    input logic        overflow
);
    `PLSI_ASSERT_IMP(a_acc_ovf, clk, rst_n, out_valid, !(accepted && overflow), "acc and ovf")
    `PLSI_ASSERT_IMP(a_odd, clk, rst_n, out_valid, !total_pairs[0], "odd pair count")
    `PLSI_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid, "valid dropped")
endmodule

bind pair_list_sort_index_builder_top plsi_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .total_pairs(total_pairs), .accepted(accepted), .overflow(overflow)
);

[tb/testbench.sv]
module testbench;
    import plsi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The hardware store holds this many entries; one offer takes two of them.
    localparam int NUM_PARTICLES = DefMaxParticles;
    localparam int NUM_SLOTS     = DefMaxPairs;
    localparam int RANDOM_ITEMS  = 100;
    // Longest quiet stretch tolerated: a build over a couple of hundred
    // entries is a quadratic walk, so leave generous room.
    localparam int QUIET_LIMIT   = 600000;
    localparam logic [2:0] CMD_UNKNOWN_LO  = 3'd5;
    localparam logic [2:0] CMD_UNKNOWN_MID = 3'd6;
    localparam logic [2:0] CMD_UNKNOWN_HI  = 3'd7;
    localparam logic [11:0] NO_GROUP = 12'hFFF;
    localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;

    // One result beat as the block reports it.
    typedef struct packed {
        logic [9:0]  pf;
        logic [9:0]  ps;
        logic [31:0] pd;
        logic [11:0] gs;
        logic [11:0] gc;
        logic [11:0] tot;
        logic        acc;
        logic        ovf;
    } pair_result_t;

    // One row of the directed table. Rows with lit set carry a result that
    // is plain from the command alone; the rest are predicted.
    typedef struct packed {
        logic [2:0]   cmd;
        logic [31:0]  dsq;
        logic [9:0]   first;
        logic [9:0]   second;
        logic [10:0]  position;
        logic         lit;
        pair_result_t res;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  cmd;
    logic [31:0] dist_sq;
    logic [9:0]  first;
    logic [9:0]  second;
    logic [10:0] position;
    logic        out_valid;
    logic        out_ready;
    logic [9:0]  pair_first;
    logic [9:0]  pair_second;
    logic [31:0] pair_dist;
    logic [11:0] group_start;
    logic [11:0] group_count;
    logic [11:0] total_pairs;
    logic        accepted;
    logic        overflow;

    pair_list_sort_index_builder_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .dist_sq    (dist_sq),
        .first      (first),
        .second     (second),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pair_first (pair_first),
        .pair_second(pair_second),
        .pair_dist  (pair_dist),
        .group_start(group_start),
        .group_count(group_count),
        .total_pairs(total_pairs),
        .accepted   (accepted),
        .overflow   (overflow)
    );

    // Shadow copy of the neighbor list: the pair store, the per-particle
    // index and the two registers.
    logic [9:0]  nl_first [NUM_SLOTS];
    logic [9:0]  nl_second[NUM_SLOTS];
    logic [31:0] nl_dist  [NUM_SLOTS];
    logic [11:0] idx_start[NUM_PARTICLES];
    logic [11:0] idx_count[NUM_PARTICLES];
    int          nl_count;
    logic [31:0] cut_reg;
    logic [10:0] pcount_reg;

    pair_result_t  pending_results[$];
    directed_row_t dir_rows[$];

    int mismatches;
    int beats_sent;
    int beats_seen;
    int accepted_pairs;
    int overflow_hits;
    int builds_done;
    int passes_done;
    int idle_mode;
    int quiet_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch on beat %0d: %s got 0x%0h, expected 0x%0h", beats_seen, what, got,
                 want);
        mismatches++;
    endtask

    // Stable insertion sort by first particle, then distance, followed by
    // the index build. Only particles that appear get their entry rewritten.
    task automatic sort_and_index();
        int k;
        int p;
        int start;
        logic [9:0]  f;
        logic [9:0]  s;
        logic [31:0] d;
        for (k = 1; k < nl_count; k++)
        begin
            f = nl_first[k];
            s = nl_second[k];
            d = nl_dist[k];
            p = k;
            while (p > 0 && (f < nl_first[p-1] || (f == nl_first[p-1] && d < nl_dist[p-1])))
            begin
                nl_first[p]  = nl_first[p-1];
                nl_second[p] = nl_second[p-1];
                nl_dist[p]   = nl_dist[p-1];
                p--;
            end
            nl_first[p]  = f;
            nl_second[p] = s;
            nl_dist[p]   = d;
        end
        if (nl_count > 0)
        begin
            start = 0;
            for (p = 1; p <= nl_count; p++)
            begin
                if (p == nl_count || nl_first[p] != nl_first[start])
                begin
                    idx_start[nl_first[start]] = 12'(start);
                    idx_count[nl_first[start]] = 12'(p - start);
                    start = p;
                end
            end
        end
    endtask

    // Advance the shadow neighbor list by one command and return its answer.
    task automatic neighbor_step(input logic [2:0] c, input logic [31:0] d, input logic [9:0] f,
                                 input logic [9:0] s, input logic [10:0] pos,
                                 output pair_result_t r);
        int i;
        r = '0;
        r.gs = NO_GROUP;
        case (c)
            CMD_OFFER:
            begin
                if (d < cut_reg)
                begin
                    if (nl_count + 2 <= NUM_SLOTS)
                    begin
                        nl_first[nl_count]    = f;
                        nl_second[nl_count]   = s;
                        nl_dist[nl_count]     = d;
                        nl_first[nl_count+1]  = s;
                        nl_second[nl_count+1] = f;
                        nl_dist[nl_count+1]   = d;
                        nl_count += 2;
                        r.acc = 1'b1;
                    end
                    else
                        r.ovf = 1'b1;
                end
            end
            CMD_BUILD:
                sort_and_index();
            CMD_RPAIR:
            begin
                if (int'(pos) < nl_count)
                begin
                    r.pf = nl_first[pos];
                    r.ps = nl_second[pos];
                    r.pd = nl_dist[pos];
                end
            end
            CMD_RIDX:
            begin
                r.gs = idx_start[f];
                r.gc = idx_count[f];
            end
            CMD_BEGIN:
            begin
                nl_count = 0;
                for (i = 0; i < NUM_PARTICLES && i < int'(pcount_reg); i++)
                begin
                    idx_start[i] = NO_GROUP;
                    idx_count[i] = '0;
                end
            end
            default:
                ;
        endcase
        r.tot = 12'(nl_count);
    endtask

    // Present one beat and hold it until the block takes it. Valid is left
    // high, unless a random gap is drawn, so that a following beat can go out without a bubble.
    task automatic send_beat(input logic [2:0] c, input logic [31:0] d, input logic [9:0] f,
                             input logic [9:0] s, input logic [10:0] pos, input logic lit,
                             input pair_result_t lit_res);
        pair_result_t r;
        int gap_pct;
        cmd      <= c;
        dist_sq  <= d;
        first    <= f;
        second   <= s;
        position <= pos;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        neighbor_step(c, d, f, s, pos, r);
        if (c == CMD_BUILD)
            builds_done++;
        pending_results.push_back(lit ? lit_res : r);
        beats_sent++;
        gap_pct = (idle_mode == 0) ? 38 : (idle_mode == 1) ? 76 : 0;
        if ($urandom_range(99, 0) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1))
                @(posedge clk);
        end
    endtask

    task automatic send_cmd(input logic [2:0] c, input logic [31:0] d, input logic [9:0] f,
                            input logic [9:0] s, input logic [10:0] pos);
        send_beat(c, d, f, s, pos, 1'b0, '0);
    endtask

    // Stop sending until every outstanding answer is back, then let a begin
    // that clears many index entries finish before anything else happens.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (int'(pcount_reg) + 20)
            @(posedge clk);
    endtask

    // Registers are only touched while the block is quiet. The enable is
    // left high between the two writes and dropped once at the end.
    task automatic write_regs(input logic [31:0] cut, input logic [10:0] pc);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CUTOFF;
        cfg_data  <= cut;
        @(posedge clk);
        cfg_index <= CFG_PCOUNT;
        cfg_data  <= {21'd0, pc};
        @(posedge clk);
        cfg_we    <= 1'b0;
        cut_reg    = cut;
        pcount_reg = pc;
    endtask

    task automatic add_row(input logic [2:0] c, input logic [31:0] d, input logic [9:0] f,
                           input logic [9:0] s, input logic [10:0] pos, input logic lit,
                           input logic [11:0] tot);
        directed_row_t row;
        row.cmd      = c;
        row.dsq      = d;
        row.first    = f;
        row.second   = s;
        row.position = pos;
        row.lit      = lit;
        row.res      = '0;
        row.res.gs   = NO_GROUP;
        row.res.tot  = tot;
        dir_rows.push_back(row);
    endtask

    // Answers are checked against the oldest outstanding prediction, field
    // by field. The ready line is redrawn every cycle according to the
    // current idle mode.
    always @(posedge clk)
    begin
        pair_result_t want;
        int stall_pct;
        if (rst_n && out_valid && out_ready)
        begin
            beats_seen++;
            if (pending_results.size() == 0)
            begin
                $display("unexpected result beat %0d with nothing outstanding", beats_seen);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (pair_first !== want.pf)
                    report("pair_first", 32'(pair_first), 32'(want.pf));
                if (pair_second !== want.ps)
                    report("pair_second", 32'(pair_second), 32'(want.ps));
                if (pair_dist !== want.pd)
                    report("pair_dist", pair_dist, want.pd);
                if (group_start !== want.gs)
                    report("group_start", 32'(group_start), 32'(want.gs));
                if (group_count !== want.gc)
                    report("group_count", 32'(group_count), 32'(want.gc));
                if (total_pairs !== want.tot)
                    report("total_pairs", 32'(total_pairs), 32'(want.tot));
                if (accepted !== want.acc)
                    report("accepted", 32'(accepted), 32'(want.acc));
                if (overflow !== want.ovf)
                    report("overflow", 32'(overflow), 32'(want.ovf));
                if (want.acc)
                    accepted_pairs++;
                if (want.ovf)
                    overflow_hits++;
            end
        end
        stall_pct = (idle_mode == 0) ? 76 : (idle_mode == 1) ? 38 : 0;
        out_ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // Watchdog: a long stretch with no beat moving on either side means the
    // block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int i;
        int n;
        int k;
        int split;
        int random_beats;
        int base;
        logic [9:0]  pa;
        logic [9:0]  pb;
        logic [31:0] d;
        logic [31:0] tie_dist;
        logic [31:0] cut;
        logic [10:0] pc;

        // Everything driven to a known value before the first edge.
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        cmd          = CMD_OFFER;
        dist_sq      = '0;
        first        = '0;
        second       = '0;
        position     = '0;
        out_ready    = 1'b0;
        mismatches   = 0;
        beats_sent   = 0;
        beats_seen   = 0;
        accepted_pairs = 0;
        overflow_hits  = 0;
        builds_done  = 0;
        passes_done  = 0;
        quiet_cycles = 0;
        idle_mode    = 2;
        nl_count     = 0;
        cut_reg      = '0;
        pcount_reg   = '0;
        for (i = 0; i < NUM_SLOTS; i++)
        begin
            nl_first[i]  = '0;
            nl_second[i] = '0;
            nl_dist[i]   = '0;
        end
        for (i = 0; i < NUM_PARTICLES; i++)
        begin
            idx_start[i] = NO_GROUP;
            idx_count[i] = '0;
        end

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. The first rows run on the reset registers: a zero
        // cutoff rejects everything and the index is empty everywhere.
        add_row(CMD_RIDX, '0, 10'd0, '0, '0, 1'b1, 12'd0);
        add_row(CMD_RIDX, '0, 10'd1023, '0, '0, 1'b1, 12'd0);
        add_row(CMD_OFFER, '0, 10'd5, 10'd7, '0, 1'b1, 12'd0);
        add_row(CMD_RPAIR, '0, '0, '0, 11'd0, 1'b1, 12'd0);
        add_row(CMD_UNKNOWN_LO, DIST_MAX, 10'd1023, 10'd1023, 11'd2047, 1'b1, 12'd0);
        split = dir_rows.size();
        // With a real cutoff: extremes of particles and distance, a distance
        // right on the cutoff, a self pair, and a tie in first and distance
        // so that arrival order decides.
        add_row(CMD_OFFER, 32'd999, 10'd1023, 10'd0, '0, 1'b0, '0);
        add_row(CMD_OFFER, 32'd1000, 10'd1, 10'd2, '0, 1'b1, 12'd2);
        add_row(CMD_OFFER, DIST_MAX, 10'd1, 10'd2, '0, 1'b1, 12'd2);
        add_row(CMD_OFFER, 32'd0, 10'd3, 10'd3, '0, 1'b0, '0);
        add_row(CMD_OFFER, 32'd500, 10'd1023, 10'd3, '0, 1'b0, '0);
        add_row(CMD_OFFER, 32'd500, 10'd3, 10'd1023, '0, 1'b0, '0);
        add_row(CMD_BUILD, '0, '0, '0, '0, 1'b0, '0);
        add_row(CMD_RPAIR, '0, '0, '0, 11'd0, 1'b0, '0);
        add_row(CMD_RPAIR, '0, '0, '0, 11'd3, 1'b0, '0);
        add_row(CMD_RPAIR, '0, '0, '0, 11'd7, 1'b0, '0);
        add_row(CMD_RPAIR, '0, '0, '0, 11'd8, 1'b0, '0);
        add_row(CMD_RPAIR, '0, '0, '0, 11'd2047, 1'b0, '0);
        add_row(CMD_RIDX, '0, 10'd3, '0, '0, 1'b0, '0);
        add_row(CMD_RIDX, '0, 10'd1023, '0, '0, 1'b0, '0);
        add_row(CMD_RIDX, '0, 10'd512, '0, '0, 1'b0, '0);
        add_row(CMD_UNKNOWN_HI, '0, '0, '0, '0, 1'b0, '0);
        add_row(CMD_UNKNOWN_MID, '0, '0, '0, '0, 1'b0, '0);
        add_row(CMD_BEGIN, '0, '0, '0, '0, 1'b0, '0);
        add_row(CMD_RIDX, '0, 10'd3, '0, '0, 1'b0, '0);

        for (i = 0; i < dir_rows.size(); i++)
        begin
            if (i == split)
            begin
                wait_quiet();
                write_regs(32'd1000, 11'd1024);
            end
            send_beat(dir_rows[i].cmd, dir_rows[i].dsq, dir_rows[i].first,
                      dir_rows[i].second, dir_rows[i].position, dir_rows[i].lit,
                      dir_rows[i].res);
        end

        // Random passes. Each pass begins, offers a batch of pairs drawn
        // mostly from a small cluster of particles so that groups form,
        // builds in most passes, and then reads pairs and index entries back.
        // Some passes change the registers first, which also makes the sender
        // wait for every outstanding answer.
        random_beats = 0;
        while (random_beats < RANDOM_ITEMS)
        begin
            idle_mode = (random_beats * 3) / RANDOM_ITEMS;
            k = beats_sent;
            if ($urandom_range(2, 0) == 0 || passes_done == 0)
            begin
                wait_quiet();
                case ($urandom_range(7, 0))
                    0:       cut = '0;
                    1:       cut = DIST_MAX;
                    2:       cut = $urandom_range(64, 1);
                    default: cut = $urandom();
                endcase
                case ($urandom_range(5, 0))
                    0:       pc = 11'd0;
                    1:       pc = 11'd1024;
                    2:       pc = 11'd2047;
                    default: pc = 11'($urandom_range(2047, 0));
                endcase
                write_regs(cut, pc);
            end
            send_cmd(CMD_BEGIN, $urandom(), 10'($urandom()), 10'($urandom()), 11'($urandom()));
            base = $urandom_range(1023, 0);
            tie_dist = (cut_reg == 0) ? '0 : $urandom_range(cut_reg - 1, 0);
            n = ($urandom_range(14, 0) == 0) ? $urandom_range(100, 40) : $urandom_range(24, 0);
            for (i = 0; i < n; i++)
            begin
                pa = ($urandom_range(3, 0) == 0) ? 10'($urandom()) :
                     10'(base + $urandom_range(7, 0));
                pb = ($urandom_range(3, 0) == 0) ? 10'($urandom()) :
                     10'(base + $urandom_range(7, 0));
                case ($urandom_range(9, 0))
                    0:       d = cut_reg;
                    1:       d = $urandom();
                    2, 3:    d = tie_dist;
                    default: d = (cut_reg == 0) ? '0 : $urandom_range(cut_reg - 1, 0);
                endcase
                if ($urandom_range(9, 0) == 0)
                    send_cmd(3'($urandom_range(7, 5)), $urandom(), 10'($urandom()),
                             10'($urandom()), 11'($urandom()));
                send_cmd(CMD_OFFER, d, pa, pb, 11'($urandom()));
            end
            if ($urandom_range(9, 0) != 0)
                send_cmd(CMD_BUILD, $urandom(), 10'($urandom()), 10'($urandom()),
                         11'($urandom()));
            // An occasional offer after the build leaves the store partly unsorted.
            if ($urandom_range(5, 0) == 0)
                send_cmd(CMD_OFFER, tie_dist, 10'(base), 10'($urandom()), '0);
            repeat ($urandom_range(12, 4))
            begin
                if ($urandom_range(1, 0) == 0)
                    send_cmd(CMD_RPAIR, $urandom(), 10'($urandom()), 10'($urandom()),
                             ($urandom_range(4, 0) == 0 || nl_count == 0) ?
                             11'($urandom()) : 11'($urandom_range(nl_count - 1, 0)));
                else
                    send_cmd(CMD_RIDX, $urandom(),
                             ($urandom_range(3, 0) == 0) ? 10'($urandom()) :
                             10'(base + $urandom_range(7, 0)),
                             10'($urandom()), 11'($urandom()));
            end
            random_beats += beats_sent - k;
            passes_done++;
        end

        // Fill the store to the brim, then push past it: the overflow flag
        // must rise without the count moving. No build here, since a sort
        // over a full store would take far too long.
        idle_mode = 2;
        wait_quiet();
        write_regs(DIST_MAX, 11'd1024);
        send_cmd(CMD_BEGIN, '0, '0, '0, '0);
        for (i = 0; i < NUM_SLOTS / 2; i++)
            send_cmd(CMD_OFFER, $urandom_range(32'hFFFF_FFFE, 0), 10'($urandom()),
                     10'($urandom()), '0);
        send_cmd(CMD_OFFER, 32'd0, 10'd1023, 10'd0, '0);
        send_cmd(CMD_OFFER, DIST_MAX, 10'd1, 10'd1, '0);
        send_cmd(CMD_RPAIR, '0, '0, '0, 11'd2047);
        send_cmd(CMD_RPAIR, '0, '0, '0, 11'd0);
        send_cmd(CMD_BEGIN, '0, '0, '0, '0);
        send_cmd(CMD_RPAIR, '0, '0, '0, 11'd0);

        wait_quiet();
        repeat (50)
            @(posedge clk);

        $display("covered %0d beats over %0d random passes and %0d builds", beats_sent,
                 passes_done, builds_done);
        $display("%0d pairs stored, %0d overflow answers, %0d results checked", accepted_pairs,
                 overflow_hits, beats_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
